// File: hw/rtl/spectrum_db_heatmap_pixel_unit_defines.svh
// Assertion macros for the waterfall heat-map pixel unit.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SPECTRUM_DB_HEATMAP_PIXEL_UNIT_DEFINES_SVH
`define SPECTRUM_DB_HEATMAP_PIXEL_UNIT_DEFINES_SVH

// Check a property while out of reset.
`define SDHP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SDHP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/sdhp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the waterfall heat-map pixel unit.
// No dependencies; imported by sdhp_div, the top level and the bench.
package sdhp_pkg;

    localparam int LOG_FRAC  = 16;
    localparam int PWR_FRAC  = 16;
    localparam int MANT_W    = 31;
    localparam int MANT_FRAC = 30;
    localparam int LOG_INT_W = 7;
    localparam int LOG_W     = LOG_INT_W + LOG_FRAC;
    localparam int K_W       = 20;
    localparam int PROD_W    = 44;
    localparam int CFG_W     = 16;
    localparam int D_W       = CFG_W + 1;
    localparam int LVL_W     = 24;
    localparam int CMP_W     = 32;
    localparam int NUM_W     = 36;
    localparam int DEN_W     = 20;
    localparam int CHAN_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [K_W-1:0] DB_PER_LOG2_Q16 = K_W'(394566);

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_FLOOR_DB = 2'd0;
    localparam cfg_idx_t CFG_MIN_DB   = 2'd1;
    localparam cfg_idx_t CFG_MAX_DB   = 2'd2;

    localparam logic signed [CFG_W-1:0] MAX_DB_RESET = 16'sd12800;

    typedef struct packed {
        logic [NUM_W-2:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

endpackage

// File: hw/rtl/spectrum_db_heatmap_pixel_unit.sv
`timescale 1ns / 1ps
// Waterfall heat-map pixel unit: bin power in, RGB pixel out.
// Depends on sdhp_pkg, sdhp_div and spectrum_db_heatmap_pixel_unit_defines.svh.
//
// Usage:
//   s_axis carries one bin power per request (tdata, unsigned Q16.16) and the
//   line-end mark (tlast). m_axis returns one pixel per request, red, green
//   and blue in tdata, with the line-end mark copied to tlast.
//   cfg writes floor_db, min_db and max_db (signed Q8.8) by index; it is
//   always ready and must only be used while no request is in flight.
// Throughput:
//   One request per cycle sustained while m_axis takes each pixel.
//   The depth is set by the sixteen mantissa squaring stages of the log2,
//   one 31x31 multiply each, plus eight divider steps per color channel.
// Reset:
//   Clears every stage valid bit and loads the register defaults
//   (floor 0, min 0, max 50 dB).
// Stall:
//   When the output holds a pixel that is not taken, the whole pipeline
//   holds and s_axis_tready drops; nothing is lost or repeated.
`include "spectrum_db_heatmap_pixel_unit_defines.svh"

module spectrum_db_heatmap_pixel_unit #(
    parameter int POWER_WIDTH  = 32,
    parameter int DB_FRAC_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [POWER_WIDTH-1:0] bin_power, zero filled to whole bytes
    input  logic [((POWER_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [3*sdhp_pkg::CHAN_W-1:0]         m_axis_tdata,
    output logic                                  m_axis_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  sdhp_pkg::cfg_idx_t                    cfg_index,
    input  logic [sdhp_pkg::CFG_W-1:0]            cfg_data
);
    import sdhp_pkg::*;

    localparam int P_W   = $clog2(POWER_WIDTH);
    localparam int SH    = 2 * LOG_FRAC - DB_FRAC_BITS;
    localparam int DEPTH = LOG_FRAC + 5 + CHAN_W + 1;

    logic en;

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] line_reg;

    logic signed [CFG_W-1:0] floor_reg;
    logic signed [CFG_W-1:0] min_reg;
    logic signed [CFG_W-1:0] max_reg;

    // Configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= '0;
            min_reg   <= '0;
            max_reg   <= MAX_DB_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FLOOR_DB: floor_reg <= cfg_data;
                CFG_MIN_DB:   min_reg   <= cfg_data;
                CFG_MAX_DB:   max_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Pipeline control: advance unless the output holds an untaken pixel
    assign en            = !vld_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg <= {line_reg[DEPTH-2:0], s_axis_tlast};
        end
    end

    // Normalize: leading one and Q1.30 mantissa
    logic [POWER_WIDTH-1:0]           pwr;
    logic [P_W-1:0]                   lead;
    logic [POWER_WIDTH+MANT_FRAC-1:0] pwr_ext;

    assign pwr     = s_axis_tdata[POWER_WIDTH-1:0];
    assign pwr_ext = {pwr, {MANT_FRAC{1'b0}}} >> lead;

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < POWER_WIDTH; i++)
        begin
            if (pwr[i])
            begin
                lead = P_W'(i);
            end
        end
    end

    logic [MANT_W-1:0]   m_reg    [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] frac_reg [0:LOG_FRAC];
    logic [P_W-1:0]      p_reg    [0:LOG_FRAC];
    logic                zero_reg [0:LOG_FRAC];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]    <= pwr_ext[MANT_W-1:0];
            frac_reg[0] <= '0;
            p_reg[0]    <= lead;
            zero_reg[0] <= pwr == '0;
        end
    end

    // log2 fraction: one truncating square per stage
    for (genvar k = 0; k < LOG_FRAC; k++)
    begin : g_sq
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     sq_sh;

        assign sq    = m_reg[k] * m_reg[k];
        assign sq_sh = sq[MANT_FRAC+MANT_W:MANT_FRAC];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[k+1]    <= sq_sh[MANT_W] ? sq_sh[MANT_W:1] : sq_sh[MANT_W-1:0];
                frac_reg[k+1] <= {frac_reg[k][LOG_FRAC-2:0], sq_sh[MANT_W]};
                p_reg[k+1]    <= p_reg[k];
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    // Scale log2 to dB
    logic signed [LOG_INT_W-1:0] log_int;
    logic signed [LOG_W-1:0]     log_val;
    logic signed [PROD_W-1:0]    prod_next;
    logic signed [PROD_W-1:0]    prod_reg;
    logic                        zero_m_reg;

    assign log_int   = signed'(LOG_INT_W'(p_reg[LOG_FRAC])) - LOG_INT_W'(PWR_FRAC);
    assign log_val   = {log_int, frac_reg[LOG_FRAC]};
    assign prod_next = log_val * DB_PER_LOG2_Q16;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            zero_m_reg <= zero_reg[LOG_FRAC];
        end
    end

    // Round, add floor, offset by min
    logic signed [PROD_W-1:0] rnd;
    logic signed [PROD_W-1:0] db;
    logic signed [LVL_W-1:0]  n_next;
    logic signed [D_W-1:0]    d_next;
    logic signed [LVL_W-1:0]  n_reg;
    logic signed [D_W-1:0]    d_reg;
    logic                     ok_reg;

    assign rnd    = prod_reg + (PROD_W'(1) <<< (SH - 1));
    assign db     = rnd >>> SH;
    assign n_next = LVL_W'(db) + LVL_W'(floor_reg) - LVL_W'(min_reg);
    assign d_next = D_W'(max_reg) - D_W'(min_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg  <= n_next;
            d_reg  <= d_next;
            ok_reg <= !zero_m_reg && (max_reg > min_reg);
        end
    end

    // Breakpoint tests
    logic signed [CMP_W-1:0] n10;
    logic signed [CMP_W-1:0] dw;
    logic signed [LVL_W-1:0] n_c_reg;
    logic signed [D_W-1:0]   d_c_reg;
    logic                    ok_c_reg;
    logic                    b_rise_reg;
    logic                    b_fall_reg;
    logic                    g_rise_reg;
    logic                    g_fall_reg;
    logic                    r_on_reg;

    assign n10 = CMP_W'(n_reg) * CMP_W'(10);
    assign dw  = CMP_W'(d_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_c_reg    <= n_reg;
            d_c_reg    <= d_reg;
            ok_c_reg   <= ok_reg;
            b_rise_reg <= n10 <= dw * 2;
            b_fall_reg <= n10 > dw * 2 && n10 <= dw * 7;
            g_rise_reg <= n10 >= dw * 2 && n10 <= dw * 6;
            g_fall_reg <= n10 > dw * 6 && n10 <= dw * 9;
            r_on_reg   <= n10 >= dw * 5;
        end
    end

    // Ramp numerators and denominators
    logic signed [NUM_W-1:0] nn;
    logic signed [NUM_W-1:0] dd;
    logic signed [NUM_W-1:0] b_num;
    logic signed [NUM_W-1:0] g_num;
    logic signed [NUM_W-1:0] r_num;
    logic [DEN_W-1:0]        b_den;
    logic [DEN_W-1:0]        g_den;
    logic [DEN_W-1:0]        r_den;
    div_req_t                b_req_reg;
    div_req_t                g_req_reg;
    div_req_t                r_req_reg;

    assign nn    = NUM_W'(n_c_reg);
    assign dd    = NUM_W'(d_c_reg);
    assign b_num = b_rise_reg ? nn * NUM_W'(1275)
                              : (dd * NUM_W'(14) - nn * NUM_W'(20)) * NUM_W'(255);
    assign g_num = g_rise_reg ? (nn * NUM_W'(10) - dd * NUM_W'(2)) * NUM_W'(255)
                              : (dd * NUM_W'(9) - nn * NUM_W'(10)) * NUM_W'(255);
    assign r_num = (nn * NUM_W'(2) - dd) * NUM_W'(255);
    assign b_den = b_rise_reg ? DEN_W'(d_c_reg) : DEN_W'(d_c_reg) * DEN_W'(10);
    assign g_den = g_rise_reg ? DEN_W'(d_c_reg) * DEN_W'(4) : DEN_W'(d_c_reg) * DEN_W'(3);
    assign r_den = DEN_W'(d_c_reg);

    // Drop a channel to num 0, den 1 when it is outside its ramp, its numerator is not positive or ok_c_reg is low
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ok_c_reg && (b_rise_reg || b_fall_reg) && b_num > 0)
            begin
                b_req_reg <= '{num: b_num[NUM_W-2:0], den: b_den};
            end
            else
            begin
                b_req_reg <= '{num: '0, den: DEN_W'(1)};
            end
            if (ok_c_reg && (g_rise_reg || g_fall_reg) && g_num > 0)
            begin
                g_req_reg <= '{num: g_num[NUM_W-2:0], den: g_den};
            end
            else
            begin
                g_req_reg <= '{num: '0, den: DEN_W'(1)};
            end
            if (ok_c_reg && r_on_reg && r_num > 0)
            begin
                r_req_reg <= '{num: r_num[NUM_W-2:0], den: r_den};
            end
            else
            begin
                r_req_reg <= '{num: '0, den: DEN_W'(1)};
            end
        end
    end

    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    sdhp_div #(
        .NUM_W (NUM_W - 1),
        .DEN_W (DEN_W),
        .Q_W   (CHAN_W)
    ) u_div_red (
        .clk  (clk),
        .en   (en),
        .req  (r_req_reg),
        .quot (red)
    );

    sdhp_div #(
        .NUM_W (NUM_W - 1),
        .DEN_W (DEN_W),
        .Q_W   (CHAN_W)
    ) u_div_green (
        .clk  (clk),
        .en   (en),
        .req  (g_req_reg),
        .quot (green)
    );

    sdhp_div #(
        .NUM_W (NUM_W - 1),
        .DEN_W (DEN_W),
        .Q_W   (CHAN_W)
    ) u_div_blue (
        .clk  (clk),
        .en   (en),
        .req  (b_req_reg),
        .quot (blue)
    );

    assign m_axis_tvalid = vld_reg[DEPTH-1];
    assign m_axis_tdata  = {blue, green, red};
    assign m_axis_tlast  = line_reg[DEPTH-1];

    // Full red only at or above the top of the scale, where blue and green are off
    `SDHP_ASSERT(a_red_full_alone, m_axis_tvalid && red == '1 |-> green == '0 && blue == '0, "red saturated with green or blue lit")
    // Full blue only at the blue peak, below the red ramp
    `SDHP_ASSERT(a_blue_full_no_red, m_axis_tvalid && blue == '1 |-> red == '0, "blue saturated with red lit")
    // Reset empties the pipeline
    `SDHP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !m_axis_tvalid, "pixel valid right after reset")

endmodule

// File: hw/rtl/sdhp_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider lane: floor(num/den) saturated to Q_W bits.
// One quotient bit per stage after an input register; uses sdhp_pkg::div_req_t.
module sdhp_div #(
    parameter int NUM_W = 35,
    parameter int DEN_W = 20,
    parameter int Q_W   = 8
) (
    input  logic                     clk,
    input  logic                     en,
    input  sdhp_pkg::div_req_t       req,
    output logic [Q_W-1:0]           quot
);
    import sdhp_pkg::*;

    localparam int R_W = DEN_W + Q_W;

    logic [R_W-1:0]   rem_reg [0:Q_W];
    logic [DEN_W-1:0] den_reg [0:Q_W];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic             sat_reg [0:Q_W];

    logic [NUM_W-1:0] den_top;

    assign den_top = NUM_W'({req.den, {Q_W{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg[0] <= NUM_W'(req.num) >= den_top;
            rem_reg[0] <= req.num[R_W-1:0];
            den_reg[0] <= req.den;
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic [R_W-1:0] den_sh;
        logic           take;

        assign den_sh = R_W'(den_reg[k]) << (Q_W - 1 - k);
        assign take   = rem_reg[k] >= den_sh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= (take && !sat_reg[k]) ? rem_reg[k] - den_sh : rem_reg[k];
                den_reg[k+1] <= den_reg[k];
                sat_reg[k+1] <= sat_reg[k];
                q_reg[k+1]   <= {q_reg[k][Q_W-2:0], take || sat_reg[k]};
            end
        end
    end

    assign quot = q_reg[Q_W];

endmodule

// File: tb/spectrum_db_heatmap_pixel_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the waterfall heat-map pixel unit: bin powers in,
// predicted RGB pixels compared in order. Depends on sdhp_pkg and the unit.
module spectrum_db_heatmap_pixel_unit_tb;
    import sdhp_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       line_last;
    } pixel_t;

    class pixel_scoreboard;
        logic signed [15:0] floor_db, min_db, max_db;
        pixel_t pending[$];
        int errors;

        function new();
            floor_db = 0;
            min_db = 0;
            max_db = 16'sd12800;
            errors = 0;
        endfunction

        function longint power_log2(longint unsigned x);
            int p;
            longint unsigned m;
            longint frac;
            p = 31;
            frac = 0;
            while (p > 0 && x[p] == 1'b0)
                p--;
            if (p > 30)
                m = x >> (p - 30);
            else
                m = x << (30 - p);
            for (int i = 0; i < 16; i++)
            begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd2 << 30))
                begin
                    frac = frac | 1;
                    m = m >> 1;
                end
            end
            return longint'(p - 16) * 65536 + frac;
        endfunction

        function logic [7:0] ramp(longint num, longint den);
            longint q;
            if (num <= 0)
                return 8'd0;
            q = num / den;
            return (q > 255) ? 8'd255 : q[7:0];
        endfunction

        function void note_request(logic [31:0] pwr, logic lend);
            pixel_t px;
            longint prod, db, n, d, n10;
            px = '0;
            px.line_last = lend;
            if (pwr != 0 && max_db > min_db)
            begin
                prod = power_log2(pwr) * 394566 + (64'sd1 << 23);
                db = prod >>> 24;
                n = longint'(floor_db) + db - longint'(min_db);
                d = longint'(max_db) - longint'(min_db);
                n10 = 10 * n;
                if (n10 <= 2 * d)
                    px.blue = ramp(255 * 5 * n, d);
                else if (n10 <= 7 * d)
                    px.blue = ramp(255 * (14 * d - 20 * n), 10 * d);
                if (n10 >= 2 * d && n10 <= 6 * d)
                    px.green = ramp(255 * (n10 - 2 * d), 4 * d);
                else if (n10 > 6 * d && n10 <= 9 * d)
                    px.green = ramp(255 * (9 * d - n10), 3 * d);
                if (n10 >= 5 * d)
                    px.red = ramp(255 * (2 * n - d), d);
            end
            pending.push_back(px);
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t exp_px;
            if (pending.size() == 0)
            begin
                $error("unexpected pixel %h", got);
                errors++;
                return;
            end
            exp_px = pending.pop_front();
            if (got.red !== exp_px.red)
            begin
                $error("red exp %0d got %0d", exp_px.red, got.red);
                errors++;
            end
            if (got.green !== exp_px.green)
            begin
                $error("green exp %0d got %0d", exp_px.green, got.green);
                errors++;
            end
            if (got.blue !== exp_px.blue)
            begin
                $error("blue exp %0d got %0d", exp_px.blue, got.blue);
                errors++;
            end
            if (got.line_last !== exp_px.line_last)
            begin
                $error("line_last exp %0d got %0d", exp_px.line_last, got.line_last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_idx_t    cfg_index;
    logic [15:0] cfg_data;

    pixel_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles = 0;

    spectrum_db_heatmap_pixel_unit dut (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel({m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                            m_axis_tlast});
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("spectrum_db_heatmap_pixel_unit test failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        case (idx)
            CFG_FLOOR_DB: sb.floor_db = value;
            CFG_MIN_DB:   sb.min_db = value;
            default:      sb.max_db = value;
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (40)
            @(negedge clk);
    endtask

    task automatic set_scale(logic [15:0] fl, logic [15:0] lo, logic [15:0] hi);
        drain();
        write_reg(CFG_FLOOR_DB, fl);
        write_reg(CFG_MIN_DB, lo);
        write_reg(CFG_MAX_DB, hi);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_bin(logic [31:0] pwr, logic lend);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pwr;
        s_axis_tlast  <= lend;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(pwr, lend);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_power();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(31);
            2: return 32'd1 << $urandom_range(31);
            default: return $urandom_range(3);
        endcase
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(59) == 0)
            begin
                if ($urandom_range(3) == 0)
                    set_scale(16'($urandom), 16'($urandom), 16'($urandom));
                else
                    set_scale(16'($urandom_range(8000) - 4000),
                              16'($urandom_range(6000) - 3000),
                              16'($urandom_range(30000)));
            end
            send_bin(rand_power(), $urandom_range(15) == 0);
        end
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 13;
        recv_idle_pct = 74;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FLOOR_DB;
        cfg_data = '0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_bin(32'd0, 1'b0);
        send_bin(32'd1, 1'b0);
        send_bin(32'hFFFF_FFFF, 1'b1);
        send_bin(32'h0001_0000, 1'b0);
        send_bin(32'h8000_0000, 1'b0);
        send_bin(32'h0003_0000, 1'b1);
        set_scale(16'd0, 16'd0, 16'd10240);
        for (int k = 0; k < 12; k++)
            send_bin(32'd1 << (k * 3), k[0]);
        set_scale(16'h8000, 16'h8000, 16'h7FFF);
        send_bin(32'hFFFF_FFFF, 1'b1);
        send_bin(32'd1, 1'b0);
        set_scale(16'h7FFF, 16'd100, 16'd100);
        send_bin(32'h1234_5678, 1'b0);
        set_scale(16'd0, 16'd2000, 16'd1000);
        send_bin(32'h0010_0000, 1'b1);
        set_scale(16'd0, 16'd0, 16'd12800);

        random_phase(480);
        send_idle_pct = 74;
        recv_idle_pct = 13;
        random_phase(480);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(480);

        drain();
        if (sb.errors == 0)
            $display("spectrum_db_heatmap_pixel_unit test passed");
        else
            $display("spectrum_db_heatmap_pixel_unit test failed");
        $finish;
    end
endmodule
